@@ rtl/cdq_pkg.sv @@
// cdq_pkg: sizes, request codes and storage helpers for the circular deque
// used by cdq_ram users and by circular_deque; no dependencies

package cdq_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int DATA_WIDTH = 32;

   // field widths on the ports
   localparam int VAL_W = 32;
   localparam int REQ_W = 3;
   localparam int CAP_W = 11;

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   localparam int REQ_DATA_W = ((VAL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * VAL_W + 3;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   localparam int CAP_RESET_INT = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_RESET_INT);

   localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INS_REAR  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PEEK      = 3'd4;

   // value as kept in a slot
   function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
      return DATA_WIDTH'(v);
   endfunction

   // slot contents back to a port value, sign-extended or truncated
   function automatic logic [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] s);
      return VAL_W'($signed(s));
   endfunction

endpackage

@@ rtl/cdq_ram.sv @@
// cdq_ram: generic simple dual-port ram, one write port and one read port
// with registered read data; no dependencies

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/circular_deque.sv @@
// circular_deque: top level of the double-ended queue over a ring of slots
// depends on cdq_pkg and cdq_ram
//
// Requests arrive on req_ (kind in req_tuser, value in req_tdata) and each one
// gives one response on rsp_ with the accepted flag, the front and rear values
// after the request (all ones when empty) and the empty and full flags. Inserts,
// peeks, unknown kinds and a delete of the last element answer from the idle
// state; a delete that leaves elements answers from ST_READ, once the new end
// value is back from the slot ram, whose read data is registered. The front and
// rear values are cached in registers, so the ram sees at most one write or one
// read per request and a read never meets a write to the same slot in the same
// cycle. A new request is taken once the previous one has finished and its
// response is taken or being taken. Writing the capacity register (0 acts as 1,
// values above the slot count act as the slot count) empties the deque.

module circular_deque (
   input  logic                             clock,
   input  logic                             reset,
   // capacity register
   input  logic                             csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]        csr_wr_data,
   // requests
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cdq_pkg::REQ_DATA_W-1:0]   req_tdata,  // data_value
   input  logic [cdq_pkg::REQ_W-1:0]        req_tuser,  // req_type
   // responses
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted, front_value, rear_value, empty_flag, full_flag, zero pad
   output logic [cdq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W = cdq_pkg::IDX_W;
   localparam int CNT_W = cdq_pkg::CNT_W;
   localparam int VAL_W = cdq_pkg::VAL_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [IDX_W-1:0]         rear_ff, rear_in;
   logic [VAL_W-1:0]         front_val_ff, front_val_in;
   logic [VAL_W-1:0]         rear_val_ff, rear_val_in;
   logic                     rd_front_ff, rd_front_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [cdq_pkg::DATA_WIDTH-1:0] ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [cdq_pkg::DATA_WIDTH-1:0] ram_rd_data;

   logic             req_accept;
   logic             ok;
   logic             is_empty;
   logic             is_full;
   logic [VAL_W-1:0] req_value;
   logic [VAL_W-1:0] out_front;
   logic [VAL_W-1:0] out_rear;
   logic             out_empty;
   logic             out_full;
   logic [CNT_W-1:0] cap_clamped;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] inc;
      inc = (CNT_W+1)'(i) + (CNT_W+1)'(1);
      return (inc >= (CNT_W+1)'(cap)) ? '0 : IDX_W'(inc);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] top;
      top = cap - CNT_W'(1);
      return ((i == '0) || (CNT_W'(i) >= cap)) ? IDX_W'(top) : i - IDX_W'(1);
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign req_value  = req_tdata[VAL_W-1:0];
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff >= cap_ff);

   always_comb begin
      if (csr_wr_data == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(cdq_pkg::MAX_SLOTS)) begin
         cap_clamped = CNT_W'(cdq_pkg::MAX_SLOTS);
      end else begin
         cap_clamped = CNT_W'(csr_wr_data);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      front_val_in = front_val_ff;
      rear_val_in  = rear_val_ff;
      rd_front_in  = rd_front_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = cdq_pkg::to_store(req_value);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      ok           = 1'b0;
      out_front    = front_val_ff;
      out_rear     = rear_val_ff;
      out_empty    = 1'b0;
      out_full     = 1'b0;

      if (state_ff == ST_READ) begin
         if (rd_front_ff) begin
            front_val_in = cdq_pkg::from_store(ram_rd_data);
         end else begin
            rear_val_in = cdq_pkg::from_store(ram_rd_data);
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cdq_pkg::RSP_PAD_W'(0), (count_ff >= cap_ff), 1'b0,
                         rear_val_in, front_val_in, 1'b1};
         state_in     = ST_IDLE;
      end else if (req_accept) begin
         unique case (req_tuser)
            cdq_pkg::REQ_INS_FRONT, cdq_pkg::REQ_INS_REAR: begin
               if (!is_full) begin
                  ok        = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  ram_wr_en = 1'b1;
                  if (is_empty) begin
                     front_in     = '0;
                     rear_in      = '0;
                     ram_wr_addr  = '0;
                     front_val_in = cdq_pkg::from_store(ram_wr_data);
                     rear_val_in  = cdq_pkg::from_store(ram_wr_data);
                  end else if (req_tuser == cdq_pkg::REQ_INS_FRONT) begin
                     front_in     = ring_prev(front_ff, cap_ff);
                     ram_wr_addr  = front_in;
                     front_val_in = cdq_pkg::from_store(ram_wr_data);
                  end else begin
                     rear_in      = ring_next(rear_ff, cap_ff);
                     ram_wr_addr  = rear_in;
                     rear_val_in  = cdq_pkg::from_store(ram_wr_data);
                  end
               end
            end
            cdq_pkg::REQ_DEL_FRONT, cdq_pkg::REQ_DEL_REAR: begin
               if (!is_empty) begin
                  ok = 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     count_in = '0;
                     front_in = '0;
                     rear_in  = '0;
                  end else begin
                     // new end value comes from the ram next cycle
                     count_in  = count_ff - CNT_W'(1);
                     ram_rd_en = 1'b1;
                     state_in  = ST_READ;
                     if (req_tuser == cdq_pkg::REQ_DEL_FRONT) begin
                        front_in    = ring_next(front_ff, cap_ff);
                        ram_rd_addr = front_in;
                        rd_front_in = 1'b1;
                     end else begin
                        rear_in     = ring_prev(rear_ff, cap_ff);
                        ram_rd_addr = rear_in;
                        rd_front_in = 1'b0;
                     end
                  end
               end
            end
            cdq_pkg::REQ_PEEK: begin
               ok = 1'b1;
            end
            default: begin
               ok = 1'b0;
            end
         endcase

         out_empty = (count_in == '0);
         out_full  = (count_in >= cap_ff);
         out_front = out_empty ? '1 : front_val_in;
         out_rear  = out_empty ? '1 : rear_val_in;
         if (state_in == ST_IDLE) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {cdq_pkg::RSP_PAD_W'(0), out_full, out_empty,
                            out_rear, out_front, ok};
         end
      end

      if (csr_wr_en) begin
         cap_in   = cap_clamped;
         count_in = '0;
         front_in = '0;
         rear_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= cdq_pkg::CAP_RESET;
         count_ff     <= '0;
         front_ff     <= '0;
         rear_ff      <= '0;
         rd_front_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         rd_front_ff  <= rd_front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_val_ff <= front_val_in;
      rear_val_ff  <= rear_val_in;
      rsp_data_ff  <= rsp_data_in;
   end

   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_WIDTH),
      .DEPTH (cdq_pkg::MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
